[src/dtq_pkg.sv]
// ----------------------------------------------------------------------------
// dtq_pkg
// Shared types and constants for the deadline timer queue.
// ----------------------------------------------------------------------------
`default_nettype none

package dtq_pkg;

    localparam int DEFAULT_TIMER_SLOTS = 16;

    localparam int TIME_W  = 48;
    localparam int DELAY_W = 32;
    localparam int ID_W    = 32;
    localparam int WAIT_W  = 32;
    localparam int KIND_W  = 3;

    typedef enum logic [1:0] {
        CMD_TICK     = 2'd0,
        CMD_ONESHOT  = 2'd1,
        CMD_PERIODIC = 2'd2,
        CMD_CANCEL   = 2'd3
    } cmd_t;

    typedef enum logic [KIND_W-1:0] {
        EVT_STARTED   = 3'd0,
        EVT_EXPIRED   = 3'd1,
        EVT_CANCELLED = 3'd2,
        EVT_NOT_FOUND = 3'd3,
        EVT_FULL      = 3'd4
    } evt_t;

    // one timer slot as stored in the slot memory
    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [TIME_W-1:0]  deadline;
        logic [DELAY_W-1:0] interval;
        logic               periodic;
    } slot_rec_t;

endpackage

`default_nettype wire

[src/deadline_timer_queue.sv]
// ----------------------------------------------------------------------------
// deadline_timer_queue
// Table of one-shot and periodic timers served in earliest-deadline order.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: a word (command, now_ms, span_ms, cancel_id) is taken
//   on a rising edge with start high and busy low. busy stays high until the
//   last result word of that command has been issued.
//   Result channel: each result word is shown for exactly one cycle with
//   result_valid high; the receiver cannot stall, so it must take it then.
//   Start and cancel give exactly one word; a tick gives one word per due
//   timer (earliest deadline first, ties to lower id, then lower slot) and
//   none if nothing is due. last marks the final word of a command.
// Scan: one slot is visited per cycle by a single scan engine that owns
//   one comparator pair and one saturating adder.
//   start  : scan up to the lowest free slot (all slots if full), then summary
//   cancel : scan up to the matching slot (all slots if none), then summary
//   tick   : the marking/summary pass, then one min search over the
//            table for each expired timer.
//   Summary fields (wait_ms, any_pending, armed_count) describe the table
//   after the whole command and are repeated on every word of that command.
// Reset: all slots empty, next id 1, busy low. Slot memory contents are not
//   cleared; entries are only read behind their valid bits.
// ----------------------------------------------------------------------------
`default_nettype none

module deadline_timer_queue
    import dtq_pkg::*;
#(
    parameter int TIMER_SLOTS = DEFAULT_TIMER_SLOTS,
    localparam int CNT_W = $clog2(TIMER_SLOTS + 1)
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    // command channel
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [1:0]          command,
    input  wire logic [TIME_W-1:0]   now_ms,
    input  wire logic [DELAY_W-1:0]  span_ms,
    input  wire logic [ID_W-1:0]     cancel_id,
    // result channel
    output logic                     result_valid,
    output logic [KIND_W-1:0]        event_kind,
    output logic [ID_W-1:0]          event_id,
    output logic [WAIT_W-1:0]        wait_ms,
    output logic                     any_pending,
    output logic [CNT_W-1:0]         armed_count,
    output logic                     last
);

    localparam int IDX_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam logic [CNT_W-1:0] SLOT_CNT  = CNT_W'(TIMER_SLOTS);
    localparam logic [IDX_W-1:0] SLOT_LAST = IDX_W'(TIMER_SLOTS - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIND,   // start: look for lowest free slot
        ST_MATCH,  // cancel: look for lowest slot holding the id
        ST_WRITE,  // start: fill the chosen slot
        ST_SUMM,   // summary pass (tick: also marks due slots)
        ST_FIN,    // turn summary into wait_ms
        ST_PICK,   // tick: min search over due slots
        ST_EXP     // tick: issue one expiry, retire or re-arm the slot
    } state_t;

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    state_t                state_reg,      state_next;
    cmd_t                  cmd_reg,        cmd_next;
    logic [TIME_W-1:0]     now_reg,        now_next;
    logic [DELAY_W-1:0]    delay_reg,      delay_next;
    logic [ID_W-1:0]       cid_reg,        cid_next;
    logic [ID_W-1:0]       next_id_reg,    next_id_next;

    logic [TIMER_SLOTS-1:0] valid_reg,     valid_next;
    logic [TIMER_SLOTS-1:0] due_reg,       due_next;

    // scan engine: address counter and one stage behind the memory read
    logic [CNT_W-1:0]      idx_reg,        idx_next;
    logic                  p_v_reg,        p_v_next;
    logic [IDX_W-1:0]      p_idx_reg,      p_idx_next;
    logic [IDX_W-1:0]      sel_reg,        sel_next;

    // summary accumulators
    logic [CNT_W-1:0]      cnt_reg,        cnt_next;
    logic                  have_reg,       have_next;
    logic [TIME_W-1:0]     best_reg,       best_next;
    logic [CNT_W-1:0]      due_cnt_reg,    due_cnt_next;
    logic [WAIT_W-1:0]     wait_hold_reg,  wait_hold_next;

    // pick (min search) accumulators
    logic                  pk_have_reg,    pk_have_next;
    logic [TIME_W-1:0]     pk_dl_reg,      pk_dl_next;
    logic [ID_W-1:0]       pk_id_reg,      pk_id_next;
    logic [DELAY_W-1:0]    pk_int_reg,     pk_int_next;
    logic                  pk_per_reg,     pk_per_next;
    logic [IDX_W-1:0]      pk_idx_reg,     pk_idx_next;

    // pending single result of start / cancel
    evt_t                  rkind_reg,      rkind_next;
    logic [ID_W-1:0]       rid_reg,        rid_next;

    // result port registers
    logic                  rv_reg,         rv_next;
    evt_t                  okind_reg,      okind_next;
    logic [ID_W-1:0]       oid_reg,        oid_next;
    logic [WAIT_W-1:0]     owait_reg,      owait_next;
    logic                  oany_reg,       oany_next;
    logic [CNT_W-1:0]      ocnt_reg,       ocnt_next;
    logic                  olast_reg,      olast_next;

    // ------------------------------------------------------------------
    // slot memory: one write port, one registered read port
    // ------------------------------------------------------------------
    slot_rec_t             mem [TIMER_SLOTS];
    slot_rec_t             rd_q_reg;
    logic [IDX_W-1:0]      rd_addr;
    logic                  mem_we;
    logic [IDX_W-1:0]      mem_wa;
    slot_rec_t             mem_wd;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        rd_q_reg <= mem[rd_addr];
    end

    // ------------------------------------------------------------------
    // shared datapath
    // ------------------------------------------------------------------
    logic [DELAY_W-1:0]    add_b;
    logic [TIME_W:0]       add_sum;
    logic [TIME_W-1:0]     add_sat;
    logic                  due_le;
    logic [TIME_W-1:0]     eff_dl;
    logic                  is_due;
    logic [TIME_W-1:0]     cmp_a;
    logic [TIME_W-1:0]     cmp_b;
    logic                  cmp_lt;
    logic                  cmp_eq;
    logic [TIME_W:0]       wdiff;
    logic [WAIT_W-1:0]     wait_c;
    logic                  scan_more;
    logic                  scan_end;

    // saturating now + interval/delay
    always_comb
    begin
        case (state_reg)
            ST_WRITE: add_b = delay_reg;
            ST_SUMM:  add_b = rd_q_reg.interval;
            default:  add_b = pk_int_reg;
        endcase
        add_sum = {1'b0, now_reg} + (TIME_W + 1)'(add_b);
        add_sat = add_sum[TIME_W] ? {TIME_W{1'b1}} : add_sum[TIME_W-1:0];
    end

    assign due_le = (rd_q_reg.deadline <= now_reg);
    assign is_due = (cmd_reg == CMD_TICK) && due_le;
    assign eff_dl = is_due ? add_sat : rd_q_reg.deadline;

    // deadline comparator shared by the summary and pick passes
    always_comb
    begin
        if (state_reg == ST_PICK)
        begin
            cmp_a = rd_q_reg.deadline;
            cmp_b = pk_dl_reg;
        end
        else
        begin
            cmp_a = eff_dl;
            cmp_b = best_reg;
        end
        cmp_lt = (cmp_a < cmp_b);
        cmp_eq = (cmp_a == cmp_b);
    end

    // wait until earliest deadline, saturated; borrow means already due
    always_comb
    begin
        wdiff = {1'b0, best_reg} - {1'b0, now_reg};
        if (!have_reg)
        begin
            wait_c = {WAIT_W{1'b1}};
        end
        else if (wdiff[TIME_W])
        begin
            wait_c = '0;
        end
        else if (wdiff[TIME_W-1:WAIT_W] != '0)
        begin
            wait_c = {WAIT_W{1'b1}};
        end
        else
        begin
            wait_c = wdiff[WAIT_W-1:0];
        end
    end

    assign scan_more = (idx_reg < SLOT_CNT);
    assign scan_end  = p_v_reg && (p_idx_reg == SLOT_LAST);
    assign rd_addr   = scan_more ? idx_reg[IDX_W-1:0] : '0;

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        now_next       = now_reg;
        delay_next     = delay_reg;
        cid_next       = cid_reg;
        next_id_next   = next_id_reg;
        valid_next     = valid_reg;
        due_next       = due_reg;
        idx_next       = idx_reg;
        p_v_next       = 1'b0;
        p_idx_next     = p_idx_reg;
        sel_next       = sel_reg;
        cnt_next       = cnt_reg;
        have_next      = have_reg;
        best_next      = best_reg;
        due_cnt_next   = due_cnt_reg;
        wait_hold_next = wait_hold_reg;
        pk_have_next   = pk_have_reg;
        pk_dl_next     = pk_dl_reg;
        pk_id_next     = pk_id_reg;
        pk_int_next    = pk_int_reg;
        pk_per_next    = pk_per_reg;
        pk_idx_next    = pk_idx_reg;
        rkind_next     = rkind_reg;
        rid_next       = rid_reg;
        rv_next        = 1'b0;
        okind_next     = okind_reg;
        oid_next       = oid_reg;
        owait_next     = owait_reg;
        oany_next      = oany_reg;
        ocnt_next      = ocnt_reg;
        olast_next     = olast_reg;
        mem_we         = 1'b0;
        mem_wa         = sel_reg;
        mem_wd         = '{id: next_id_reg, deadline: add_sat,
                           interval: (cmd_reg == CMD_PERIODIC) ? delay_reg : '0,
                           periodic: (cmd_reg == CMD_PERIODIC)};

        // common address walk of the memory scans
        if (state_reg == ST_MATCH || state_reg == ST_SUMM || state_reg == ST_PICK)
        begin
            if (scan_more)
            begin
                p_v_next   = 1'b1;
                p_idx_next = idx_reg[IDX_W-1:0];
                idx_next   = idx_reg + 1'b1;
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd_next     = cmd_t'(command);
                    now_next     = now_ms;
                    delay_next   = span_ms;
                    cid_next     = cancel_id;
                    idx_next     = '0;
                    due_next     = '0;
                    cnt_next     = '0;
                    have_next    = 1'b0;
                    due_cnt_next = '0;
                    case (cmd_t'(command))
                        CMD_TICK:    state_next = ST_SUMM;
                        CMD_CANCEL:  state_next = ST_MATCH;
                        default:     state_next = ST_FIND;
                    endcase
                end
            end

            ST_FIND:
            begin
                if (scan_more)
                begin
                    if (!valid_reg[idx_reg[IDX_W-1:0]])
                    begin
                        sel_next   = idx_reg[IDX_W-1:0];
                        state_next = ST_WRITE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
                else
                begin
                    rkind_next = EVT_FULL;
                    rid_next   = '0;
                    idx_next   = '0;
                    state_next = ST_SUMM;
                end
            end

            ST_WRITE:
            begin
                mem_we              = 1'b1;
                valid_next[sel_reg] = 1'b1;
                rkind_next          = EVT_STARTED;
                rid_next            = next_id_reg;
                next_id_next        = (next_id_reg == {ID_W{1'b1}}) ? ID_W'(1)
                                                                    : next_id_reg + 1'b1;
                idx_next            = '0;
                state_next          = ST_SUMM;
            end

            ST_MATCH:
            begin
                if (p_v_reg && valid_reg[p_idx_reg] && (rd_q_reg.id == cid_reg))
                begin
                    valid_next[p_idx_reg] = 1'b0;
                    rkind_next            = EVT_CANCELLED;
                    rid_next              = cid_reg;
                    idx_next              = '0;
                    p_v_next              = 1'b0;
                    state_next            = ST_SUMM;
                end
                else if (scan_end)
                begin
                    rkind_next = EVT_NOT_FOUND;
                    rid_next   = '0;
                    idx_next   = '0;
                    p_v_next   = 1'b0;
                    state_next = ST_SUMM;
                end
            end

            ST_SUMM:
            begin
                // counts and earliest deadline of the table as it stands after
                // the command; on a tick, due one-shots drop out and due
                // periodic timers count at their re-armed deadline
                if (p_v_reg && valid_reg[p_idx_reg])
                begin
                    if (is_due)
                    begin
                        due_next[p_idx_reg] = 1'b1;
                        due_cnt_next        = due_cnt_reg + 1'b1;
                    end
                    if (!is_due || rd_q_reg.periodic)
                    begin
                        cnt_next = cnt_reg + 1'b1;
                        if (!have_reg || cmp_lt)
                        begin
                            best_next = eff_dl;
                            have_next = 1'b1;
                        end
                    end
                end
                if (scan_end)
                begin
                    state_next = ST_FIN;
                end
            end

            ST_FIN:
            begin
                wait_hold_next = wait_c;
                if (cmd_reg == CMD_TICK)
                begin
                    idx_next     = '0;
                    pk_have_next = 1'b0;
                    state_next   = (due_cnt_reg == '0) ? ST_IDLE : ST_PICK;
                end
                else
                begin
                    rv_next    = 1'b1;
                    okind_next = rkind_reg;
                    oid_next   = rid_reg;
                    owait_next = wait_c;
                    oany_next  = have_reg;
                    ocnt_next  = cnt_reg;
                    olast_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            ST_PICK:
            begin
                // earliest deadline, then lowest id; equal keys keep lower slot
                if (p_v_reg && due_reg[p_idx_reg])
                begin
                    if (!pk_have_reg || cmp_lt || (cmp_eq && rd_q_reg.id < pk_id_reg))
                    begin
                        pk_have_next = 1'b1;
                        pk_dl_next   = rd_q_reg.deadline;
                        pk_id_next   = rd_q_reg.id;
                        pk_int_next  = rd_q_reg.interval;
                        pk_per_next  = rd_q_reg.periodic;
                        pk_idx_next  = p_idx_reg;
                    end
                end
                if (scan_end)
                begin
                    state_next = ST_EXP;
                end
            end

            ST_EXP:
            begin
                rv_next    = 1'b1;
                okind_next = EVT_EXPIRED;
                oid_next   = pk_id_reg;
                owait_next = wait_hold_reg;
                oany_next  = have_reg;
                ocnt_next  = cnt_reg;
                olast_next = (due_cnt_reg == CNT_W'(1));
                due_next[pk_idx_reg] = 1'b0;
                if (pk_per_reg)
                begin
                    mem_we = 1'b1;
                    mem_wa = pk_idx_reg;
                    mem_wd = '{id: pk_id_reg, deadline: add_sat,
                               interval: pk_int_reg, periodic: 1'b1};
                end
                else
                begin
                    valid_next[pk_idx_reg] = 1'b0;
                end
                due_cnt_next = due_cnt_reg - 1'b1;
                idx_next     = '0;
                pk_have_next = 1'b0;
                state_next   = (due_cnt_reg == CNT_W'(1)) ? ST_IDLE : ST_PICK;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cmd_reg       <= CMD_TICK;
            now_reg       <= '0;
            delay_reg     <= '0;
            cid_reg       <= '0;
            next_id_reg   <= ID_W'(1);
            valid_reg     <= '0;
            due_reg       <= '0;
            idx_reg       <= '0;
            p_v_reg       <= 1'b0;
            p_idx_reg     <= '0;
            sel_reg       <= '0;
            cnt_reg       <= '0;
            have_reg      <= 1'b0;
            best_reg      <= '0;
            due_cnt_reg   <= '0;
            wait_hold_reg <= '0;
            pk_have_reg   <= 1'b0;
            pk_dl_reg     <= '0;
            pk_id_reg     <= '0;
            pk_int_reg    <= '0;
            pk_per_reg    <= 1'b0;
            pk_idx_reg    <= '0;
            rkind_reg     <= EVT_STARTED;
            rid_reg       <= '0;
            rv_reg        <= 1'b0;
            okind_reg     <= EVT_STARTED;
            oid_reg       <= '0;
            owait_reg     <= '0;
            oany_reg      <= 1'b0;
            ocnt_reg      <= '0;
            olast_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cmd_reg       <= cmd_next;
            now_reg       <= now_next;
            delay_reg     <= delay_next;
            cid_reg       <= cid_next;
            next_id_reg   <= next_id_next;
            valid_reg     <= valid_next;
            due_reg       <= due_next;
            idx_reg       <= idx_next;
            p_v_reg       <= p_v_next;
            p_idx_reg     <= p_idx_next;
            sel_reg       <= sel_next;
            cnt_reg       <= cnt_next;
            have_reg      <= have_next;
            best_reg      <= best_next;
            due_cnt_reg   <= due_cnt_next;
            wait_hold_reg <= wait_hold_next;
            pk_have_reg   <= pk_have_next;
            pk_dl_reg     <= pk_dl_next;
            pk_id_reg     <= pk_id_next;
            pk_int_reg    <= pk_int_next;
            pk_per_reg    <= pk_per_next;
            pk_idx_reg    <= pk_idx_next;
            rkind_reg     <= rkind_next;
            rid_reg       <= rid_next;
            rv_reg        <= rv_next;
            okind_reg     <= okind_next;
            oid_reg       <= oid_next;
            owait_reg     <= owait_next;
            oany_reg      <= oany_next;
            ocnt_reg      <= ocnt_next;
            olast_reg     <= olast_next;
        end
    end

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = rv_reg;
    assign event_kind   = okind_reg;
    assign event_id     = oid_reg;
    assign wait_ms      = owait_reg;
    assign any_pending  = oany_reg;
    assign armed_count  = ocnt_reg;
    assign last         = olast_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy))
        else $error("result word without a command in flight");

    a_pending_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (any_pending == (armed_count != '0)))
        else $error("any_pending disagrees with armed_count");

    a_idle_wait_max: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !any_pending) |-> (wait_ms == {WAIT_W{1'b1}}))
        else $error("empty table must report maximum wait");

    a_id_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        next_id_reg != '0)
        else $error("next id reached zero");

    a_due_only_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (due_reg & ~valid_reg) == '0)
        else $error("due mark on an empty slot");

endmodule

`default_nettype wire

[test/tb_deadline_timer_queue.sv]
// ----------------------------------------------------------------------------
// tb_deadline_timer_queue
// Self-checking bench for the deadline timer queue. A driver takes command
// words from a feed queue. On each accepted word a timer-table model
// predicts the result words, and a monitor compares every result word,
// field by field, with the oldest prediction. The first words are directed
// corner cases. After them comes a long random run: mostly well-formed
// traffic on a rising clock, with some random noise words mixed in.
// ----------------------------------------------------------------------------
module tb_deadline_timer_queue;
    timeunit 1ns;
    timeprecision 1ps;

    import dtq_pkg::*;

    localparam int SLOTS        = DEFAULT_TIMER_SLOTS;
    localparam int CNT_W        = $clog2(SLOTS + 1);
    localparam int RANDOM_ITEMS = 480;
    // A full tick runs a summary pass plus one min search per expired timer.
    // This margin covers that after the last awaited word.
    localparam int SETTLE_CYCLES = 400;
    localparam int IDLE_PCT      = 20;

    // one command word as the sender sees it
    typedef struct {
        cmd_t              op;
        logic [TIME_W-1:0] now;
        logic [DELAY_W-1:0] delay;
        logic [ID_W-1:0]   cid;
    } timer_cmd_t;

    // one result word as the block should issue it
    typedef struct {
        evt_t              kind;
        logic [ID_W-1:0]   id;
        logic [WAIT_W-1:0] wait_ms;
        logic              pending;
        logic [CNT_W-1:0]  count;
        logic              is_last;
    } timer_event_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic               start = 1'b0;
    logic [1:0]         command = CMD_TICK;
    logic [TIME_W-1:0]  now_ms = '0;
    logic [DELAY_W-1:0] span_ms = '0;
    logic [ID_W-1:0]    cancel_id = '0;

    logic               busy;
    logic               result_valid;
    logic [KIND_W-1:0]  event_kind;
    logic [ID_W-1:0]    event_id;
    logic [WAIT_W-1:0]  wait_ms;
    logic               any_pending;
    logic [CNT_W-1:0]   armed_count;
    logic               last;

    deadline_timer_queue DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .command      (command),
        .now_ms       (now_ms),
        .span_ms      (span_ms),
        .cancel_id    (cancel_id),
        .result_valid (result_valid),
        .event_kind   (event_kind),
        .event_id     (event_id),
        .wait_ms      (wait_ms),
        .any_pending  (any_pending),
        .armed_count  (armed_count),
        .last         (last)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 0;
    end

    // ------------------------------------------------------------------------
    // Timer table model: the bench's own copy of the block's state
    // ------------------------------------------------------------------------
    logic               tmr_valid    [SLOTS];
    logic [ID_W-1:0]    tmr_id       [SLOTS];
    logic [TIME_W-1:0]  tmr_deadline [SLOTS];
    logic [DELAY_W-1:0] tmr_interval [SLOTS];
    logic               tmr_periodic [SLOTS];
    logic [ID_W-1:0]    tmr_next_id;

    timer_event_t awaited_events[$];   // result words not yet seen
    timer_cmd_t   cmd_feed[$];         // command words not yet driven
    timer_cmd_t   driven_cmd;          // word currently on the command ports
    timer_event_t head_event;
    logic         no_gaps = 1'b0;      // sender drops its random idling
    int           err_count = 0;

    initial
    begin
        foreach (tmr_valid[i])
            tmr_valid[i] = 1'b0;
        tmr_next_id = 1;
    end

    // now + delay, clamped at the top of the 48-bit time range
    function automatic logic [TIME_W-1:0] deadline_at(logic [TIME_W-1:0] t,
                                                      logic [DELAY_W-1:0] d);
        logic [TIME_W:0] s;
        s = {1'b0, t} + {{(TIME_W + 1 - DELAY_W){1'b0}}, d};
        return s[TIME_W] ? '1 : s[TIME_W-1:0];
    endfunction

    // Apply one accepted command to the table and queue the words it causes.
    task automatic advance_timer_table(input timer_cmd_t c);
        logic [SLOTS-1:0]  due;
        int                pick;
        int                hit;
        int                count;
        logic              have;
        logic [TIME_W-1:0] best;
        logic [TIME_W-1:0] gap;
        logic [WAIT_W-1:0] wait_v;
        timer_event_t      ev;
        timer_event_t      words[$];

        case (c.op)
            CMD_TICK:
            begin
                foreach (tmr_valid[i])
                    due[i] = tmr_valid[i] && (tmr_deadline[i] <= c.now);
                // earliest deadline first, then lower id, then lower slot
                while (due != '0)
                begin
                    pick = -1;
                    for (int i = 0; i < SLOTS; i++)
                        if (due[i] && (pick < 0 || tmr_deadline[i] < tmr_deadline[pick] ||
                            (tmr_deadline[i] == tmr_deadline[pick] &&
                             tmr_id[i] < tmr_id[pick])))
                            pick = i;
                    due[pick] = 1'b0;
                    ev.kind = EVT_EXPIRED;
                    ev.id   = tmr_id[pick];
                    words = {words, ev};
                    // re-arm only after it left the due set: no double fire
                    if (tmr_periodic[pick])
                        tmr_deadline[pick] = deadline_at(c.now, tmr_interval[pick]);
                    else
                        tmr_valid[pick] = 1'b0;
                end
            end
            CMD_ONESHOT, CMD_PERIODIC:
            begin
                pick = -1;
                for (int i = SLOTS - 1; i >= 0; i--)
                    if (!tmr_valid[i])
                        pick = i;
                if (pick < 0)
                begin
                    ev.kind = EVT_FULL;
                    ev.id   = '0;
                end
                else
                begin
                    tmr_valid[pick]    = 1'b1;
                    tmr_id[pick]       = tmr_next_id;
                    tmr_deadline[pick] = deadline_at(c.now, c.delay);
                    tmr_periodic[pick] = (c.op == CMD_PERIODIC);
                    tmr_interval[pick] = (c.op == CMD_PERIODIC) ? c.delay : '0;
                    ev.kind = EVT_STARTED;
                    ev.id   = tmr_next_id;
                    tmr_next_id = tmr_next_id + 1;
                    if (tmr_next_id == '0)
                        tmr_next_id = 1;
                end
                words = {words, ev};
            end
            default:
            begin
                hit = -1;
                for (int i = SLOTS - 1; i >= 0; i--)
                    if (tmr_valid[i] && tmr_id[i] == c.cid)
                        hit = i;
                if (hit < 0)
                begin
                    ev.kind = EVT_NOT_FOUND;
                    ev.id   = '0;
                end
                else
                begin
                    tmr_valid[hit] = 1'b0;
                    ev.kind = EVT_CANCELLED;
                    ev.id   = c.cid;
                end
                words = {words, ev};
            end
        endcase

        // summary of the table after the whole command
        count = 0;
        have  = 1'b0;
        best  = '0;
        foreach (tmr_valid[i])
            if (tmr_valid[i])
            begin
                count++;
                if (!have || tmr_deadline[i] < best)
                    best = tmr_deadline[i];
                have = 1'b1;
            end
        if (!have)
            wait_v = '1;
        else if (best <= c.now)
            wait_v = '0;
        else
        begin
            gap = best - c.now;
            wait_v = (gap > {{(TIME_W - WAIT_W){1'b0}}, {WAIT_W{1'b1}}}) ? '1 : gap[WAIT_W-1:0];
        end

        foreach (words[k])
        begin
            words[k].wait_ms = wait_v;
            words[k].pending = have;
            words[k].count   = count[CNT_W-1:0];
            words[k].is_last = (k == words.size() - 1);
            awaited_events = {awaited_events, words[k]};
        end
    endtask

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        $display("%0t ERROR %s: got %0h, want %0h", $realtime, what, got, want);
        err_count++;
    endtask

    // ------------------------------------------------------------------------
    // Driver: a word is taken on an edge with start high and busy low.
    // Once raised, start holds its word until taken.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start     <= 1'b0;
            command   <= CMD_TICK;
            now_ms    <= '0;
            span_ms   <= '0;
            cancel_id <= '0;
        end
        else if (!(start && busy))
        begin
            if (start)
                advance_timer_table(driven_cmd);
            // next word goes out now, or the sender idles this cycle
            if (cmd_feed.size() != 0 && (no_gaps || $urandom_range(0, 99) >= IDLE_PCT))
            begin
                driven_cmd = cmd_feed.pop_front();
                start     <= 1'b1;
                command   <= driven_cmd.op;
                now_ms    <= driven_cmd.now;
                span_ms   <= driven_cmd.delay;
                cancel_id <= driven_cmd.cid;
            end
            else
                start <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: every strobed word is checked against the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (awaited_events.size() == 0)
                flag_mismatch("result word with none awaited, event_id", event_id, 0);
            else
            begin
                head_event = awaited_events.pop_front();
                if (event_kind !== head_event.kind)
                    flag_mismatch("event_kind", event_kind, head_event.kind);
                if (event_id !== head_event.id)
                    flag_mismatch("event_id", event_id, head_event.id);
                if (wait_ms !== head_event.wait_ms)
                    flag_mismatch("wait_ms", wait_ms, head_event.wait_ms);
                if (any_pending !== head_event.pending)
                    flag_mismatch("any_pending", any_pending, head_event.pending);
                if (armed_count !== head_event.count)
                    flag_mismatch("armed_count", armed_count, head_event.count);
                if (last !== head_event.is_last)
                    flag_mismatch("last", last, head_event.is_last);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    // Keep the feed short so that cancels built from the model's live ids
    // are close to the block's real state.
    task automatic queue_cmd(input cmd_t op, input logic [TIME_W-1:0] t,
                             input logic [DELAY_W-1:0] d, input logic [ID_W-1:0] id);
        timer_cmd_t c;
        c.op    = op;
        c.now   = t;
        c.delay = d;
        c.cid   = id;
        while (cmd_feed.size() >= 2)
            @(negedge clk);
        cmd_feed = {cmd_feed, c};
    endtask

    // Stop sending until the block is idle and every awaited word has come.
    task automatic wait_idle();
        while (cmd_feed.size() != 0 || start || busy || awaited_events.size() != 0)
            @(negedge clk);
    endtask

    function automatic logic [ID_W-1:0] pick_live_id();
        logic [ID_W-1:0] live[$];
        foreach (tmr_valid[i])
            if (tmr_valid[i])
                live = {live, tmr_id[i]};
        if (live.size() == 0)
            return $urandom();
        return live[$urandom_range(0, live.size() - 1)];
    endfunction

    initial
    begin : stimulus
        logic [TIME_W-1:0] clock_ms;
        int                start_lim;
        int                tick_lim;
        int                roll;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // -- directed corners --
        queue_cmd(CMD_TICK,   '0, '0, '0);            // empty tick: no word at all
        queue_cmd(CMD_CANCEL, '0, '0, '0);            // id zero is never found
        queue_cmd(CMD_ONESHOT,  48'd100, '0, '0);     // due at once, id 1
        queue_cmd(CMD_PERIODIC, 48'd100, '0, '0);     // zero interval, id 2
        queue_cmd(CMD_TICK, 48'd100, '0, '0);         // deadline tie: lower id first
        queue_cmd(CMD_TICK, 48'd100, '0, '0);         // zero interval fires again
        queue_cmd(CMD_CANCEL, 48'd100, '0, 32'd2);    // cancel hit
        // deadline clamps at the top of the time range
        queue_cmd(CMD_ONESHOT,  {TIME_W{1'b1}} - 48'd10, '1, '0);
        queue_cmd(CMD_PERIODIC, {TIME_W{1'b1}}, '1, '0);
        queue_cmd(CMD_TICK,     {TIME_W{1'b1}}, '0, '0);
        // time running backward: wait saturates
        queue_cmd(CMD_ONESHOT, 48'h0100_0000_0000, 32'd5, '0);
        queue_cmd(CMD_CANCEL,  '0, '0, 32'hFFFF_FFFF);
        // fill the table, one more start hits the full case
        for (int k = 0; k < 15; k++)
            queue_cmd((k % 5 == 4) ? CMD_PERIODIC : CMD_ONESHOT, 48'd1000,
                      (k % 4) * 10, '0);
        // every slot due in one tick: the longest burst of words
        queue_cmd(CMD_TICK, {TIME_W{1'b1}}, '0, '0);

        // -- random traffic --
        clock_ms  = {16'h0001, 32'($urandom())};
        start_lim = 40;
        tick_lim  = 75;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            // change the command mix every 40 words: balanced, fill, drain
            if (n % 40 == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       begin start_lim = 40; tick_lim = 75; end
                    1:       begin start_lim = 60; tick_lim = 85; end
                    default: begin start_lim = 15; tick_lim = 55; end
                endcase
            end
            no_gaps = (n >= 120 && n < 240);
            if (n == 240 || n == 400)
                wait_idle();

            clock_ms = clock_ms + $urandom_range(0, 30);
            if ($urandom_range(0, 99) < 8)
            begin
                // noise: any command, any time, any field
                queue_cmd(cmd_t'($urandom_range(0, 3)),
                          {16'($urandom()), 32'($urandom())}, $urandom(), $urandom());
            end
            else
            begin
                roll = $urandom_range(0, 99);
                if (roll < start_lim)
                    queue_cmd($urandom_range(0, 1) ? CMD_PERIODIC : CMD_ONESHOT, clock_ms,
                              ($urandom_range(0, 99) < 80) ? $urandom_range(0, 300)
                                                           : $urandom(),
                              $urandom());
                else if (roll < tick_lim)
                    queue_cmd(CMD_TICK, clock_ms, $urandom(), $urandom());
                else
                    queue_cmd(CMD_CANCEL, clock_ms, $urandom(),
                              ($urandom_range(0, 99) < 75) ? pick_live_id() : $urandom());
            end
        end

        wait_idle();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (err_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // hang guard, well past the slowest legal run
    initial
    begin
        #4_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[sim.f]
src/dtq_pkg.sv
src/deadline_timer_queue.sv
test/tb_deadline_timer_queue.sv
